// ===== design/rrwl_pkg.sv =====
// Package for the reentrant reader-writer lock: transaction types, action and status codes.
`default_nettype none
package rrwl_pkg;

    localparam int ACTION_W = 3;
    localparam int REQ_W    = 4;
    localparam int STATUS_W = 3;
    localparam int NEST_W   = 8;

    localparam logic [NEST_W-1:0] NEST_MAX = {NEST_W{1'b1}};

    localparam logic [ACTION_W-1:0] ACT_READ_ACQ   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_ACQ  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WITHDRAW   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_REL   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WRITE_REL  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

    typedef struct packed {
        logic                wait_if_busy;
        logic [REQ_W-1:0]    requester;
        logic [ACTION_W-1:0] action;
    } req_t;

    typedef struct packed {
        logic                wake_readers;
        logic                wake_writer;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic writer_active;
        logic write_nest_zero;
    } lock_status_t;

endpackage
`default_nettype wire

// ===== design/rrwl_in_stage.sv =====
// Input register stage: captures one request transaction and holds it until the core takes it.
`default_nettype none
module rrwl_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [2:0] action, [6:3] requester, [7] wait_if_busy
    input  wire logic          out_free,
    output logic               req_valid,
    output rrwl_pkg::req_t     req
);
    import rrwl_pkg::*;

    logic valid_reg, valid_next;
    req_t req_reg;

    assign s_tready = !valid_reg || out_free;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (out_free) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= req_t'(s_tdata);
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule
`default_nettype wire

// ===== design/rrwl_core.sv =====
// Lock state and combinational decision logic for one request.
`default_nettype none
module rrwl_core #(
    parameter int REQUESTERS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire rrwl_pkg::req_t    req,
    output rrwl_pkg::result_t      result,
    output rrwl_pkg::lock_status_t lock_status
);
    import rrwl_pkg::*;

    // Only agents reachable by the requester field need storage.
    localparam int DEPTH = (REQUESTERS < (1 << REQ_W)) ? REQUESTERS : (1 << REQ_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [NEST_W-1:0] rcount_reg [DEPTH];
    logic [NEST_W-1:0] rcount_next;
    logic              rcount_we;
    logic [DEPTH-1:0]  pend_reg, pend_next;
    logic              wactive_reg, wactive_next;
    logic [REQ_W-1:0]  owner_reg, owner_next;
    logic [NEST_W-1:0] wcount_reg, wcount_next;

    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic [DEPTH-1:0]  who_bit;
    logic [DEPTH-1:0]  held;
    logic [NEST_W-1:0] rcount;
    logic              owns_write;
    logic              parallel;
    logic              write_ok;

    assign in_range   = 32'(req.requester) < REQUESTERS;
    assign idx        = IDX_W'(req.requester);
    assign who_bit    = DEPTH'(1) << idx;
    assign rcount     = rcount_reg[idx];
    assign owns_write = wactive_reg && (owner_reg == req.requester);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            held[i] = rcount_reg[i] != '0;
        end
    end

    assign parallel = |(held & ~pend_reg & ~who_bit);
    assign write_ok = owns_write || (!wactive_reg && !parallel);

    always_comb begin
        result       = '0;
        result.status = ST_DENIED;
        rcount_next  = rcount;
        rcount_we    = 1'b0;
        pend_next    = pend_reg;
        wactive_next = wactive_reg;
        owner_next   = owner_reg;
        wcount_next  = wcount_reg;
        if (in_range) begin
            case (req.action)
                ACT_READ_ACQ: begin
                    if (!(rcount != '0 || owns_write || (!wactive_reg && pend_reg == '0))) begin
                        result.status = ST_DENIED;
                    end else if (rcount == NEST_MAX) begin
                        result.status = ST_SATURATED;
                    end else begin
                        rcount_next   = rcount + 1'b1;
                        rcount_we     = 1'b1;
                        result.status = ST_OK;
                    end
                end
                ACT_WRITE_ACQ: begin
                    if (!write_ok) begin
                        if (req.wait_if_busy) begin
                            pend_next     = pend_reg | who_bit;
                            result.status = ST_QUEUED;
                        end else begin
                            result.status = ST_DENIED;
                        end
                    end else if (owns_write && wcount_reg == NEST_MAX) begin
                        result.status = ST_SATURATED;
                    end else begin
                        wcount_next   = owns_write ? wcount_reg + 1'b1 : NEST_W'(1);
                        wactive_next  = 1'b1;
                        owner_next    = req.requester;
                        pend_next     = pend_reg & ~who_bit;
                        result.status = ST_OK;
                    end
                end
                ACT_WITHDRAW: begin
                    pend_next = pend_reg & ~who_bit;
                    result.wake_readers = (pend_reg != '0) && ((pend_reg & ~who_bit) == '0)
                                          && !wactive_reg;
                    result.status = ST_OK;
                end
                ACT_READ_REL: begin
                    if (rcount == '0) begin
                        result.status = ST_NOT_HELD;
                    end else begin
                        rcount_next  = rcount - 1'b1;
                        rcount_we    = 1'b1;
                        // parallel excludes the requester, so it is unchanged by the decrement
                        result.wake_writer = (rcount == NEST_W'(1)) && !wactive_reg && !parallel;
                        result.status = ST_OK;
                    end
                end
                ACT_WRITE_REL: begin
                    if (!owns_write || wcount_reg == '0) begin
                        result.status = ST_NOT_HELD;
                    end else begin
                        wcount_next = wcount_reg - 1'b1;
                        if (wcount_reg == NEST_W'(1)) begin
                            wactive_next        = 1'b0;
                            owner_next          = '0;
                            result.wake_readers = pend_reg == '0;
                            result.wake_writer  = pend_reg != '0;
                        end
                        result.status = ST_OK;
                    end
                end
                default: begin
                    result.status = ST_DENIED;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                rcount_reg[i] <= '0;
            end
            pend_reg    <= '0;
            wactive_reg <= 1'b0;
            owner_reg   <= '0;
            wcount_reg  <= '0;
        end else if (fire) begin
            if (rcount_we) begin
                rcount_reg[idx] <= rcount_next;
            end
            pend_reg    <= pend_next;
            wactive_reg <= wactive_next;
            owner_reg   <= owner_next;
            wcount_reg  <= wcount_next;
        end
    end

    assign lock_status.writer_active   = wactive_reg;
    assign lock_status.write_nest_zero = wcount_reg == '0;

endmodule
`default_nettype wire

// ===== design/reentrant_reader_writer_lock.sv =====
// Top level of the reentrant reader-writer lock manager with writer preference.
//
//  channel  | ports        | tdata bits (low first)
//  ---------+--------------+------------------------------------------------
//  request  | s_tvalid/rdy | action[2:0] requester[6:3] wait_if_busy[7]
//  response | m_tvalid/rdy | status[2:0] wake_writer[3] wake_readers[4] 0[7:5]
//
// One request per cycle while m_tready is high; a request transaction passes through the
// input register, then the result register, the lock state updating as the result loads.
// Reset clears all nest counts and the pending mask.
// With m_tready low the result register holds, the input register fills
// behind it and s_tready then drops until the response is taken.
`default_nettype none
module reentrant_reader_writer_lock #(
    parameter int REQUESTERS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [2:0] action, [6:3] requester, [7] wait_if_busy
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [2:0] status, [3] wake_writer, [4] wake_readers
);
    import rrwl_pkg::*;

    logic         out_free;
    logic         req_valid;
    logic         fire;
    req_t         req;
    result_t      result;
    lock_status_t lock_status;

    logic    m_valid_reg, m_valid_next;
    result_t m_data_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = req_valid && out_free;

    rrwl_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_free  (out_free),
        .req_valid (req_valid),
        .req       (req)
    );

    rrwl_core #(
        .REQUESTERS (REQUESTERS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .req         (req),
        .result      (result),
        .lock_status (lock_status)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 8'(m_data_reg);

    // Write lock held exactly when the write nest count is nonzero.
    a_writer_count: assert property (@(posedge aclk) disable iff (!aresetn)
        lock_status.writer_active == !lock_status.write_nest_zero)
        else $error("writer_active disagrees with write nest count");

    // Wake hints only accompany a successful transaction.
    a_wake_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != ST_OK) |->
            (!m_data_reg.wake_writer && !m_data_reg.wake_readers))
        else $error("wake hint on a failed request");

    // Never wake both readers and a writer at once.
    a_wake_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.wake_writer && m_data_reg.wake_readers))
        else $error("both wake hints raised");

endmodule
`default_nettype wire

// ===== test/rrwl_tb_pkg.sv =====
// Lock-state tracker class that predicts and checks responses of the reader-writer lock.
`timescale 1ns / 1ps
package rrwl_tb_pkg;

    import rrwl_pkg::*;

    localparam int AGENTS = 16;

    class lock_shadow;
        logic [NEST_W-1:0] reader_depth [AGENTS];
        logic [AGENTS-1:0] waiting_writers;
        logic              writer_busy;
        logic [REQ_W-1:0]  writer_id;
        logic [NEST_W-1:0] writer_depth;
        result_t           owed_replies [$];
        int                failures;

        function new();
            foreach (reader_depth[i]) reader_depth[i] = '0;
            waiting_writers = '0;
            writer_busy     = 1'b0;
            writer_id       = '0;
            writer_depth    = '0;
            failures        = 0;
        endfunction

        // readers other than who, ignoring those that are themselves waiting to write
        function bit others_reading(int who);
            for (int i = 0; i < AGENTS; i++) begin
                if (i != who && reader_depth[i] != 0 && !waiting_writers[i]) return 1'b1;
            end
            return 1'b0;
        endfunction

        function result_t grant_outcome(req_t r);
            result_t          res;
            logic             owns;
            logic             ok;
            logic [AGENTS-1:0] prior;
            int               who;
            res        = '0;
            res.status = ST_DENIED;
            who        = int'(r.requester);
            owns       = writer_busy && writer_id == r.requester;
            case (r.action)
                ACT_READ_ACQ: begin
                    ok = reader_depth[who] != 0 || owns ||
                         (!writer_busy && waiting_writers == '0);
                    if (!ok) begin
                        res.status = ST_DENIED;
                    end else if (reader_depth[who] == NEST_MAX) begin
                        res.status = ST_SATURATED;
                    end else begin
                        reader_depth[who] = reader_depth[who] + 1'b1;
                        res.status = ST_OK;
                    end
                end
                ACT_WRITE_ACQ: begin
                    ok = owns || (!writer_busy && !others_reading(who));
                    if (!ok) begin
                        if (r.wait_if_busy) begin
                            waiting_writers[who] = 1'b1;
                            res.status = ST_QUEUED;
                        end else begin
                            res.status = ST_DENIED;
                        end
                    end else if (owns && writer_depth == NEST_MAX) begin
                        res.status = ST_SATURATED;
                    end else begin
                        if (!owns) writer_depth = '0;
                        writer_busy          = 1'b1;
                        writer_id            = r.requester;
                        writer_depth         = writer_depth + 1'b1;
                        waiting_writers[who] = 1'b0;
                        res.status = ST_OK;
                    end
                end
                ACT_WITHDRAW: begin
                    prior = waiting_writers;
                    waiting_writers[who] = 1'b0;
                    if (prior != '0 && waiting_writers == '0 && !writer_busy)
                        res.wake_readers = 1'b1;
                    res.status = ST_OK;
                end
                ACT_READ_REL: begin
                    if (reader_depth[who] == 0) begin
                        res.status = ST_NOT_HELD;
                    end else begin
                        reader_depth[who] = reader_depth[who] - 1'b1;
                        if (reader_depth[who] == 0 && !writer_busy && !others_reading(who))
                            res.wake_writer = 1'b1;
                        res.status = ST_OK;
                    end
                end
                ACT_WRITE_REL: begin
                    if (!owns || writer_depth == 0) begin
                        res.status = ST_NOT_HELD;
                    end else begin
                        writer_depth = writer_depth - 1'b1;
                        if (writer_depth == 0) begin
                            writer_busy = 1'b0;
                            writer_id   = '0;
                            if (waiting_writers == '0) res.wake_readers = 1'b1;
                            else res.wake_writer = 1'b1;
                        end
                        res.status = ST_OK;
                    end
                end
                default: begin
                    res.status = ST_DENIED;
                end
            endcase
            return res;
        endfunction

        function void note_request(req_t r);
            owed_replies.push_back(grant_outcome(r));
        endfunction

        function void check_reply(result_t got);
            result_t want;
            if (owed_replies.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: response with no request outstanding: status %0d ww %0d wr %0d",
                             $time, got.status, got.wake_writer, got.wake_readers);
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status || got.wake_writer !== want.wake_writer ||
                got.wake_readers !== want.wake_readers) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch: expected status %0d ww %0d wr %0d, got %0d %0d %0d",
                             $time, want.status, want.wake_writer, want.wake_readers,
                             got.status, got.wake_writer, got.wake_readers);
            end
        endfunction

        function int outstanding();
            return owed_replies.size();
        endfunction
    endclass

endpackage

// ===== test/reentrant_reader_writer_lock_tb.sv =====
// Top-level testbench for the reentrant reader-writer lock: stimulus, handshakes and checking.
`timescale 1ns / 1ps
module reentrant_reader_writer_lock_tb;

    import rrwl_pkg::*;
    import rrwl_tb_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED_5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;
    localparam int STALL_LIMIT = 2000;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    lock_shadow shadow = new();
    bit         no_gaps = 1'b0;
    int         idle_cycles = 0;

    reentrant_reader_writer_lock #(.REQUESTERS(AGENTS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 5);
    endfunction

    // one request transaction; the expectation is formed at the accepting edge
    task automatic push_req(input logic [ACTION_W-1:0] act, input logic [REQ_W-1:0] who,
                            input logic hold);
        req_t r;
        int   gap;
        r.action       = act;
        r.requester    = who;
        r.wait_if_busy = hold;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do @(posedge aclk); while (!s_tready);
        shadow.note_request(r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (shadow.outstanding() > 0) @(posedge aclk);
    endtask

    // release everything held and drop all pending marks
    task automatic free_lock();
        for (int i = 0; i < AGENTS; i++) begin
            while (shadow.reader_depth[i] != 0)
                push_req(ACT_READ_REL, REQ_W'(i), 1'($urandom_range(0, 1)));
        end
        while (shadow.writer_busy) push_req(ACT_WRITE_REL, shadow.writer_id, 1'b0);
        for (int i = 0; i < AGENTS; i++) begin
            if (shadow.waiting_writers[i])
                push_req(ACT_WITHDRAW, REQ_W'(i), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic nest_to_saturation();
        logic [REQ_W-1:0] who;
        who = REQ_W'($urandom_range(0, AGENTS - 1));
        repeat (257) push_req(ACT_READ_ACQ, who, 1'($urandom_range(0, 1)));
        // owner keeps writing while holding a saturated read count
        repeat (257) push_req(ACT_WRITE_ACQ, who, 1'($urandom_range(0, 1)));
        push_req(ACT_READ_ACQ, who, 1'b0);
        repeat (256) push_req(ACT_WRITE_REL, who, 1'b0);
        repeat (256) push_req(ACT_READ_REL, who, 1'b0);
    endtask

    task automatic random_item(input logic [REQ_W-1:0] pool [4]);
        logic [REQ_W-1:0] who;
        int               pick;
        who  = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 3)]
                                             : REQ_W'($urandom_range(0, AGENTS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 25) push_req(ACT_READ_ACQ, who, 1'($urandom_range(0, 1)));
        else if (pick < 50) push_req(ACT_WRITE_ACQ, who, 1'($urandom_range(0, 1)));
        else if (pick < 58) push_req(ACT_WITHDRAW, who, 1'($urandom_range(0, 1)));
        else if (pick < 78) push_req(ACT_READ_REL, who, 1'($urandom_range(0, 1)));
        else if (pick < 95) begin
            if (shadow.writer_busy && $urandom_range(0, 1)) who = shadow.writer_id;
            push_req(ACT_WRITE_REL, who, 1'($urandom_range(0, 1)));
        end else begin
            push_req(ACTION_W'(ACT_WRITE_REL + $urandom_range(1, 3)), who,
                     1'($urandom_range(0, 1)));
        end
    endtask

    // response side
    initial begin
        int      stall;
        result_t got;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata[4:0];
            shadow.check_reply(got);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic [REQ_W-1:0] pool [4];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: errors from idle, unused actions, reentry, writer preference, wakes
        push_req(ACT_WRITE_REL, 4'd0, 1'b0);
        push_req(ACT_READ_REL, 4'd0, 1'b0);
        push_req(ACT_UNUSED_5, 4'd15, 1'b1);
        push_req(ACT_UNUSED_6, 4'd15, 1'b0);
        push_req(ACT_UNUSED_7, 4'd15, 1'b1);
        push_req(ACT_READ_ACQ, 4'd1, 1'b0);
        push_req(ACT_READ_ACQ, 4'd1, 1'b1);
        push_req(ACT_READ_ACQ, 4'd2, 1'b0);
        push_req(ACT_WRITE_ACQ, 4'd1, 1'b0);
        push_req(ACT_WRITE_ACQ, 4'd1, 1'b1);
        push_req(ACT_READ_ACQ, 4'd3, 1'b0);
        push_req(ACT_READ_ACQ, 4'd2, 1'b0);
        push_req(ACT_WITHDRAW, 4'd1, 1'b0);
        push_req(ACT_WRITE_ACQ, 4'd3, 1'b1);
        push_req(ACT_WRITE_ACQ, 4'd1, 1'b1);
        push_req(ACT_READ_REL, 4'd2, 1'b0);
        push_req(ACT_READ_REL, 4'd2, 1'b0);
        push_req(ACT_WRITE_ACQ, 4'd1, 1'b0);
        push_req(ACT_WRITE_ACQ, 4'd1, 1'b0);
        push_req(ACT_READ_ACQ, 4'd1, 1'b0);
        push_req(ACT_WRITE_ACQ, 4'd3, 1'b1);
        push_req(ACT_READ_ACQ, 4'd0, 1'b0);
        push_req(ACT_WRITE_REL, 4'd3, 1'b0);
        push_req(ACT_WRITE_REL, 4'd1, 1'b0);
        push_req(ACT_WRITE_REL, 4'd1, 1'b0);
        free_lock();

        for (int epoch = 0; epoch < 8; epoch++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            foreach (pool[i]) pool[i] = REQ_W'($urandom_range(0, AGENTS - 1));
            repeat (100) random_item(pool);
            if (epoch == 3) begin
                no_gaps = 1'b0;
                wait_drained();
                free_lock();
                nest_to_saturation();
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (shadow.failures == 0 && shadow.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
